FILE: sv/mdts_pkg.sv
// mdts_pkg: shared constants, codes and controller/datapath interface types
// for the mean distance top-three selector; no dependencies
package mdts_pkg;

   localparam int DIST_BITS_DEF = 31;
   localparam int ATOM_BITS_DEF = 8;
   localparam int CTX_BITS = 10;
   localparam int CNT_BITS = 17;
   localparam int CFG_BITS = 16;
   localparam int RANK_BITS = 2;
   localparam int NUM_SLOTS = 3;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [RANK_BITS-1:0] RANK_FIRST = 2'd0;
   localparam logic [RANK_BITS-1:0] RANK_LAST = 2'd2;

   localparam logic REG_MAX_SAMPLES = 1'b0;
   localparam logic [CFG_BITS-1:0] MAX_SAMPLES_RESET = 16'd1024;

   typedef struct packed {
      logic accept;
      logic load;
      logic step;
      logic insert;
      logic emit;
      logic clear;
      logic [RANK_BITS-1:0] rank;
   } dp_cmd_type;

   typedef struct packed {
      logic div_last;
   } dp_status_type;

endpackage

FILE: sv/mean_distance_top3_selector.sv
// mean_distance_top3_selector: top level with the configuration register,
// controller and datapath; depends on mdts_pkg, mdts_ctrl, mdts_datapath
//
// A sample item without a candidate or context end leaves busy low, so items
// may follow back to back. An item that closes a candidate raises busy while
// the one-bit-per-cycle divider steps through the quotient and then during the
// sorted insert. An item that closes a context then passes through one emit
// state per ranked result; the three results appear on consecutive cycles,
// each marked by rsp_valid for one cycle. Results cannot be held off: capture
// them when rsp_valid is high.
module mean_distance_top3_selector #(
   parameter int DIST_BITS = mdts_pkg::DIST_BITS_DEF,
   parameter int ATOM_BITS = mdts_pkg::ATOM_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [mdts_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [mdts_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [mdts_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [mdts_pkg::CTX_BITS-1:0]        req_context_id,
   input  logic [ATOM_BITS-1:0]                 req_ref_atom,
   input  logic [DIST_BITS-1:0]                 req_distance,
   input  logic                                 req_sample_valid,
   input  logic                                 req_candidate_end,
   input  logic                                 req_context_end,
   output logic                                 rsp_valid,
   output logic [mdts_pkg::CTX_BITS-1:0]        rsp_out_context,
   output logic [mdts_pkg::RANK_BITS-1:0]       rsp_rank,
   output logic [ATOM_BITS-1:0]                 rsp_chosen_atom,
   output logic [DIST_BITS-1:0]                 rsp_mean_distance,
   output logic                                 rsp_slot_valid,
   output logic                                 rsp_last
);
   import mdts_pkg::*;

   logic [CFG_BITS-1:0]  max_samples_ff;
   logic                 csr_write;
   logic                 csr_hit;
   dp_cmd_type           cmd;
   dp_status_type        status;

   assign pready = 1'b1;
   assign csr_hit = (paddr[2] == REG_MAX_SAMPLES);
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata = csr_hit ? CSR_DATA_BITS'(max_samples_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_samples_ff <= MAX_SAMPLES_RESET;
      end else if (csr_write && csr_hit) begin
         max_samples_ff <= pwdata[CFG_BITS-1:0];
      end
   end

   mdts_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_candidate_end (req_candidate_end),
      .req_context_end   (req_context_end),
      .status            (status),
      .cmd               (cmd)
   );

   mdts_datapath #(
      .DIST_BITS (DIST_BITS),
      .ATOM_BITS (ATOM_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .max_samples       (max_samples_ff),
      .req_context_id    (req_context_id),
      .req_ref_atom      (req_ref_atom),
      .req_distance      (req_distance),
      .req_sample_valid  (req_sample_valid),
      .rsp_valid         (rsp_valid),
      .rsp_out_context   (rsp_out_context),
      .rsp_rank          (rsp_rank),
      .rsp_chosen_atom   (rsp_chosen_atom),
      .rsp_mean_distance (rsp_mean_distance),
      .rsp_slot_valid    (rsp_slot_valid),
      .rsp_last          (rsp_last)
   );

endmodule

FILE: sv/mdts_ctrl.sv
// mdts_ctrl: sequencer for sample intake, mean division, top-three insert
// and result emission; depends on mdts_pkg
module mdts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_candidate_end,
   input  logic                    req_context_end,
   input  mdts_pkg::dp_status_type status,
   output mdts_pkg::dp_cmd_type    cmd
);
   import mdts_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_INSERT,
      ST_EMIT
   } state_type;

   state_type             state_ff;
   logic                  ctx_end_ff;
   logic [RANK_BITS-1:0]  rank_ff;
   logic                  accept;
   logic                  closes;

   assign busy = (state_ff != ST_IDLE);
   assign accept = start && (state_ff == ST_IDLE);
   assign closes = req_candidate_end || req_context_end;

   always_comb begin
      cmd = '0;
      cmd.accept = accept;
      cmd.load = accept && closes;
      cmd.step = (state_ff == ST_DIVIDE);
      cmd.insert = (state_ff == ST_INSERT);
      cmd.emit = (state_ff == ST_EMIT);
      cmd.clear = (state_ff == ST_EMIT) && (rank_ff == RANK_LAST);
      cmd.rank = rank_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ctx_end_ff <= 1'b0;
         rank_ff <= RANK_FIRST;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept && closes) begin
                  ctx_end_ff <= req_context_end;
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (status.div_last) begin
                  state_ff <= ST_INSERT;
               end
            end
            ST_INSERT: begin
               rank_ff <= RANK_FIRST;
               state_ff <= ctx_end_ff ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
               if (rank_ff == RANK_LAST) begin
                  state_ff <= ST_IDLE;
               end else begin
                  rank_ff <= rank_ff + RANK_BITS'(1);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: sv/mdts_datapath.sv
// mdts_datapath: sample accumulator, radix-2 restoring divider, sorted
// three-entry table and result registers; depends on mdts_pkg
module mdts_datapath #(
   parameter int DIST_BITS = mdts_pkg::DIST_BITS_DEF,
   parameter int ATOM_BITS = mdts_pkg::ATOM_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mdts_pkg::dp_cmd_type              cmd,
   output mdts_pkg::dp_status_type           status,
   input  logic [mdts_pkg::CFG_BITS-1:0]     max_samples,
   input  logic [mdts_pkg::CTX_BITS-1:0]     req_context_id,
   input  logic [ATOM_BITS-1:0]              req_ref_atom,
   input  logic [DIST_BITS-1:0]              req_distance,
   input  logic                              req_sample_valid,
   output logic                              rsp_valid,
   output logic [mdts_pkg::CTX_BITS-1:0]     rsp_out_context,
   output logic [mdts_pkg::RANK_BITS-1:0]    rsp_rank,
   output logic [ATOM_BITS-1:0]              rsp_chosen_atom,
   output logic [DIST_BITS-1:0]              rsp_mean_distance,
   output logic                              rsp_slot_valid,
   output logic                              rsp_last
);
   import mdts_pkg::*;

   localparam int SUM_BITS = DIST_BITS + CNT_BITS - 1;
   localparam int STEP_BITS = $clog2(DIST_BITS);

   logic [SUM_BITS-1:0]   sum_ff, sum_in, load_sum;
   logic [CNT_BITS-1:0]   count_ff, count_in, load_count;
   logic                  keep;

   logic [CNT_BITS-1:0]   rem_ff, rem_in;
   logic [DIST_BITS-1:0]  quo_ff;
   logic [CNT_BITS-1:0]   divisor_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic [CNT_BITS:0]     trial, diff;
   logic                  ge;

   logic [ATOM_BITS-1:0]  atom_ff;
   logic [CTX_BITS-1:0]   ctx_ff;

   logic [DIST_BITS-1:0]  best_mean_ff [NUM_SLOTS];
   logic [ATOM_BITS-1:0]  best_atom_ff [NUM_SLOTS];
   logic [DIST_BITS-1:0]  best_mean_in [NUM_SLOTS];
   logic [ATOM_BITS-1:0]  best_atom_in [NUM_SLOTS];
   logic [DIST_BITS-1:0]  shift_mean [NUM_SLOTS];
   logic [ATOM_BITS-1:0]  shift_atom [NUM_SLOTS];
   logic [RANK_BITS-1:0]  filled_ff;
   logic                  found;

   logic [DIST_BITS-1:0]  sel_mean;
   logic [ATOM_BITS-1:0]  sel_atom;
   logic                  sel_ok;

   // accumulation
   always_comb begin
      keep = req_sample_valid && (count_ff < {1'b0, max_samples});
      load_sum = keep ? sum_ff + SUM_BITS'(req_distance) : sum_ff;
      load_count = keep ? count_ff + CNT_BITS'(1) : count_ff;
      sum_in = sum_ff;
      count_in = count_ff;
      if (cmd.accept) begin
         sum_in = cmd.load ? '0 : load_sum;
         count_in = cmd.load ? '0 : load_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         count_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         atom_ff <= req_ref_atom;
         ctx_ff <= req_context_id;
      end
   end

   // divider: quotient fits in DIST_BITS, so the upper sum bits seed the
   // remainder; a zero divisor yields all ones
   always_comb begin
      trial = {rem_ff, quo_ff[DIST_BITS-1]};
      diff = trial - {1'b0, divisor_ff};
      ge = (trial >= {1'b0, divisor_ff});
      rem_in = ge ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
   end

   assign status.div_last = (step_ff == STEP_BITS'(DIST_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.load) begin
         step_ff <= '0;
      end else if (cmd.step) begin
         step_ff <= step_ff + STEP_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff <= CNT_BITS'(load_sum[SUM_BITS-1:DIST_BITS]);
         quo_ff <= load_sum[DIST_BITS-1:0];
         divisor_ff <= load_count;
      end else if (cmd.step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DIST_BITS-2:0], ge};
      end
   end

   // sorted insert
   always_comb begin
      shift_mean[0] = best_mean_ff[0];
      shift_atom[0] = best_atom_ff[0];
      for (int i = 1; i < NUM_SLOTS; i++) begin
         shift_mean[i] = best_mean_ff[i-1];
         shift_atom[i] = best_atom_ff[i-1];
      end
   end

   always_comb begin
      found = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         best_mean_in[i] = best_mean_ff[i];
         best_atom_in[i] = best_atom_ff[i];
         if (found) begin
            best_mean_in[i] = shift_mean[i];
            best_atom_in[i] = shift_atom[i];
         end else if ((i >= int'(filled_ff)) || (quo_ff < best_mean_ff[i]) ||
                      ((quo_ff == best_mean_ff[i]) && (atom_ff < best_atom_ff[i]))) begin
            best_mean_in[i] = quo_ff;
            best_atom_in[i] = atom_ff;
            found = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
      end else if (cmd.clear) begin
         filled_ff <= '0;
      end else if (cmd.insert && found && (filled_ff != RANK_BITS'(NUM_SLOTS))) begin
         filled_ff <= filled_ff + RANK_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         best_mean_ff <= best_mean_in;
         best_atom_ff <= best_atom_in;
      end
   end

   // result registers
   always_comb begin
      case (cmd.rank)
         2'd0: begin
            sel_mean = best_mean_ff[0];
            sel_atom = best_atom_ff[0];
         end
         2'd1: begin
            sel_mean = best_mean_ff[1];
            sel_atom = best_atom_ff[1];
         end
         default: begin
            sel_mean = best_mean_ff[2];
            sel_atom = best_atom_ff[2];
         end
      endcase
      sel_ok = (cmd.rank < filled_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_out_context <= ctx_ff;
         rsp_rank <= cmd.rank;
         rsp_chosen_atom <= sel_ok ? sel_atom : '0;
         rsp_mean_distance <= sel_ok ? sel_mean : '0;
         rsp_slot_valid <= sel_ok;
         rsp_last <= (cmd.rank == RANK_LAST);
      end
   end

endmodule

FILE: sv/mdts_checker.sv
// mdts_checker: port-level assertions for mean_distance_top3_selector and
// the bind that attaches them; depends on mdts_pkg
module mdts_checker #(
   parameter int DIST_BITS = mdts_pkg::DIST_BITS_DEF,
   parameter int ATOM_BITS = mdts_pkg::ATOM_BITS_DEF
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic                                 req_candidate_end,
   input logic                                 req_context_end,
   input logic                                 rsp_valid,
   input logic [mdts_pkg::RANK_BITS-1:0]       rsp_rank,
   input logic [ATOM_BITS-1:0]                 rsp_chosen_atom,
   input logic [DIST_BITS-1:0]                 rsp_mean_distance,
   input logic                                 rsp_slot_valid,
   input logic                                 rsp_last
);
   import mdts_pkg::*;

   // plain samples never stall intake
   a_sample_no_stall: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_candidate_end && !req_context_end) |=> !busy)
      else $error("sample item stalled intake");

   // a closing item always occupies the block
   a_close_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_candidate_end || req_context_end)) |=> busy)
      else $error("closing item did not raise busy");

   // ranks come out in order on consecutive cycles
   a_rank_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_rank == RANK_FIRST)) |=>
      (rsp_valid && (rsp_rank == RANK_FIRST + RANK_BITS'(1))) ##1
      (rsp_valid && (rsp_rank == RANK_LAST) && rsp_last))
      else $error("ranked results out of order");

   // empty slots carry zero payload
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_slot_valid) |->
      ((rsp_chosen_atom == '0) && (rsp_mean_distance == '0)))
      else $error("empty slot with nonzero payload");

   // slots fill from rank zero upward
   a_fill_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_slot_valid && (rsp_rank != RANK_FIRST)) |->
      ($past(rsp_valid) && $past(rsp_slot_valid)))
      else $error("valid slot after an empty one");

endmodule

bind mean_distance_top3_selector mdts_checker #(
   .DIST_BITS (DIST_BITS),
   .ATOM_BITS (ATOM_BITS)
) u_mdts_checker (.*);
